FILE: sv/wsfd_pkg.sv
// ============================================================================
// wsfd_pkg: shared types and codes for the WebSocket frame decoder
// Result kinds, error codes, header length escapes and the result record.
// ============================================================================
`default_nettype none

package wsfd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_ZERO_KEY = 2'd2;

  // 7-bit length escapes and the extension byte counts (minus one)
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [2:0] EXT16_LEFT  = 3'd1;
  localparam logic [2:0] EXT64_LEFT  = 3'd7;

  // Reset value of the message size limit
  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
    logic [1:0] err;
  } wsfd_result_t;

endpackage

`default_nettype wire

FILE: sv/wsfd_parser.sv
// ============================================================================
// wsfd_parser: frame header parser and payload unmasker
// Consumes one stream byte per step, updates the frame state and produces
// at most one result record for that byte.
// ============================================================================
`default_nettype none

module wsfd_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          byte_in,
  input  wire logic [31:0]         max_len,
  output wsfd_pkg::wsfd_result_t   res,
  output logic                     res_valid
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [2:0]  ext_left_r,  ext_left_nxt;
  logic [63:0] frame_rem_r, frame_rem_nxt;
  logic [32:0] msg_total_r, msg_total_nxt;
  logic [31:0] mask_key_r,  mask_key_nxt;
  logic        mask_on_r,   mask_on_nxt;
  logic [1:0]  mask_pos_r,  mask_pos_nxt;
  logic        final_r,     final_nxt;
  logic [3:0]  opcode_r,    opcode_nxt;
  logic        halted_r,    halted_nxt;

  logic        len_known;
  logic [63:0] len_val;
  logic        start_req;
  logic [63:0] ext_shift;
  logic [31:0] key_acc;
  logic [7:0]  key_byte;
  logic [33:0] total_sum;
  logic        too_long;

  assign ext_shift = {frame_rem_r[55:0], byte_in};
  assign key_acc   = mask_key_r | (32'(byte_in) << {mask_pos_r, 3'b000});
  assign key_byte  = 8'(mask_key_r >> {mask_pos_r, 3'b000});
  assign total_sum = {1'b0, msg_total_r} + {1'b0, len_val[32:0]};
  // Zero-length frames never fail, even when the limit was lowered below
  // the running total.
  assign too_long  = (len_val != 64'd0) &&
                     ((|len_val[63:33]) || (total_sum > {2'b00, max_len}));

  always_comb begin
    phase_nxt     = phase_r;
    ext_left_nxt  = ext_left_r;
    frame_rem_nxt = frame_rem_r;
    msg_total_nxt = msg_total_r;
    mask_key_nxt  = mask_key_r;
    mask_on_nxt   = mask_on_r;
    mask_pos_nxt  = mask_pos_r;
    final_nxt     = final_r;
    opcode_nxt    = opcode_r;
    halted_nxt    = halted_r;
    len_known     = 1'b0;
    len_val       = 64'd0;
    start_req     = 1'b0;
    res_valid     = 1'b0;
    res           = '{kind: KIND_DATA, data: 8'd0, opcode: opcode_r,
                      last: 1'b0, err: ERR_NONE};

    if (step && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          final_nxt = byte_in[7];
          if (opcode_r == 4'd0) begin
            opcode_nxt = byte_in[3:0];
          end
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_on_nxt   = byte_in[7];
          frame_rem_nxt = 64'd0;
          if (byte_in[6:0] == LEN_EXT16) begin
            ext_left_nxt = EXT16_LEFT;
            phase_nxt    = PH_EXT;
          end else if (byte_in[6:0] == LEN_EXT64) begin
            ext_left_nxt = EXT64_LEFT;
            phase_nxt    = PH_EXT;
          end else begin
            len_known = 1'b1;
            len_val   = 64'(byte_in[6:0]);
          end
        end
        PH_EXT: begin
          frame_rem_nxt = ext_shift;
          if (ext_left_r == 3'd0) begin
            len_known = 1'b1;
            len_val   = ext_shift;
          end else begin
            ext_left_nxt = ext_left_r - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_nxt = key_acc;
          if (mask_pos_r != 2'd3) begin
            mask_pos_nxt = mask_pos_r + 2'd1;
          end else if (key_acc == 32'd0) begin
            halted_nxt = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.err    = ERR_ZERO_KEY;
          end else begin
            start_req = 1'b1;
          end
        end
        PH_DATA: begin
          mask_pos_nxt  = mask_pos_r + 2'd1;
          frame_rem_nxt = frame_rem_r - 64'd1;
          res_valid     = 1'b1;
          res.data      = byte_in ^ key_byte;
          if (frame_rem_r == 64'd1) begin
            phase_nxt = PH_HDR0;
            res.last  = final_r;
            if (final_r) begin
              opcode_nxt    = 4'd0;
              msg_total_nxt = 33'd0;
            end
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // Frame length complete: enforce the message limit
      if (len_known) begin
        if (too_long) begin
          halted_nxt = 1'b1;
          res_valid  = 1'b1;
          res.kind   = KIND_ERROR;
          res.err    = ERR_TOO_LONG;
        end else begin
          msg_total_nxt = total_sum[32:0];
          frame_rem_nxt = len_val;
          mask_key_nxt  = 32'd0;
          mask_pos_nxt  = 2'd0;
          if (mask_on_nxt) begin
            phase_nxt = PH_MASK;
          end else begin
            start_req = 1'b1;
          end
        end
      end

      // Header done: go to payload, or close out an empty frame
      if (start_req) begin
        mask_pos_nxt = 2'd0;
        if (frame_rem_nxt == 64'd0) begin
          phase_nxt = PH_HDR0;
          if (final_r) begin
            res_valid     = 1'b1;
            res.kind      = KIND_END;
            res.last      = 1'b1;
            opcode_nxt    = 4'd0;
            msg_total_nxt = 33'd0;
          end
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      ext_left_r  <= 3'd0;
      frame_rem_r <= 64'd0;
      msg_total_r <= 33'd0;
      mask_key_r  <= 32'd0;
      mask_on_r   <= 1'b0;
      mask_pos_r  <= 2'd0;
      final_r     <= 1'b0;
      opcode_r    <= 4'd0;
      halted_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ext_left_r  <= ext_left_nxt;
      frame_rem_r <= frame_rem_nxt;
      msg_total_r <= msg_total_nxt;
      mask_key_r  <= mask_key_nxt;
      mask_on_r   <= mask_on_nxt;
      mask_pos_r  <= mask_pos_nxt;
      final_r     <= final_nxt;
      opcode_r    <= opcode_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/websocket_frame_decoder_top.sv
// ============================================================================
// websocket_frame_decoder_top: WebSocket byte stream frame decoder
// Parses frame headers, unmasks payload bytes and flags message ends and
// protocol errors, one stream byte per clock while not stalled.
// ============================================================================
// Usage
//   Input channel (in_valid / in_stall / in_byte): one raw stream byte per
//   transaction. A transaction completes when in_valid is high and in_stall
//   is low at a rising edge of clk.
//   Result channel (out_valid / out_stall / out_*): zero or one result per
//   input byte: a payload byte, an empty message end, or an error.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes the message
//   size limit; cfg_ready is always high. Write only while the block idles.
// Timing and throughput
//   A result appears on out_valid in the cycle after its byte is taken. One
//   byte per cycle is sustained while not stalled: the whole parse step is a
//   single registered update of the frame state, feeding one output register.
// Stalls
//   in_stall rises only while the output register holds a result that the
//   receiver stalls; a held result keeps its value until taken.
// Reset
//   Synchronous, active-low rst_n clears the parser (expect a frame header),
//   drops any pending result and restores the limit to 1 MiB. After an
//   error result the block ignores all input until the next reset.
// ============================================================================
`default_nettype none

module websocket_frame_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [3:0]       out_opcode,
  output logic             out_last,
  output logic [1:0]       out_error,
  // limit register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import wsfd_pkg::*;

  logic [31:0]  max_len_r;
  logic         in_fire;
  logic         out_fire;
  logic         res_valid;
  wsfd_result_t res;
  wsfd_result_t out_res_r;
  logic         out_valid_r, out_valid_nxt;

  // Output register accepts a new result if empty or draining this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .byte_in   (in_byte),
    .max_len   (max_len_r),
    .res       (res),
    .res_valid (res_valid)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // result payload, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_res_r.kind;
  assign out_byte   = out_res_r.data;
  assign out_opcode = out_res_r.opcode;
  assign out_last   = out_res_r.last;
  assign out_error  = out_res_r.err;

endmodule

`default_nettype wire

FILE: sv/wsfd_checker.sv
// ============================================================================
// wsfd_checker: result channel checks for the frame decoder
// Watches the top-level result ports and flags inconsistent results.
// ============================================================================
`default_nettype none

module wsfd_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] out_kind,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last,
  input  wire logic [1:0] out_error
);
  import wsfd_pkg::*;

  logic err_seen_r;

  // set once an error result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_kind == KIND_ERROR) begin
      err_seen_r <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_ERROR) == (out_error != ERR_NONE)) &&
                  ((out_kind != KIND_ERROR) || !out_last))
    else $error("error code and kind disagree");

  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_last && out_byte == 8'd0)
    else $error("message end item malformed");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    err_seen_r |-> !out_valid)
    else $error("result after error");

endmodule

bind websocket_frame_decoder_top wsfd_checker u_wsfd_checker (.*);

`default_nettype wire
